### rtl/cdh_pkg.sv
package cdh_pkg;

  localparam int NumProcsDefault  = 5;
  localparam int HoldDepthDefault = 8;
  localparam int ClockFields      = 5;
  localparam int CntW             = 16;
  localparam int SendW            = 3;
  localparam int TagW             = 16;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_HELD      = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_EMIT
  } state_t;

  // per-cell report toward the controller
  typedef struct packed {
    logic             valid;
    logic             ready;
    logic [SendW-1:0] sender;
    logic [TagW-1:0]  tag;
  } cell_stat_t;

endpackage

### rtl/cdh_cell.sv
module cdh_cell import cdh_pkg::*; #(
  parameter int NUM_PROCS = NumProcsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          shift,
  input  logic                          clear,
  input  logic [SendW-1:0]              load_sender,
  input  logic [TagW-1:0]               load_tag,
  input  logic [NUM_PROCS*CntW-1:0]     load_clock,
  input  logic                          nb_valid,
  input  logic [SendW-1:0]              nb_sender,
  input  logic [TagW-1:0]               nb_tag,
  input  logic [NUM_PROCS*CntW-1:0]     nb_clock,
  input  logic [NUM_PROCS*CntW-1:0]     counts,
  output cell_stat_t                    stat,
  output logic [NUM_PROCS*CntW-1:0]     clock_out
);

  logic                      valid;
  logic [SendW-1:0]          sender;
  logic [TagW-1:0]           tag;
  logic [NUM_PROCS*CntW-1:0] vclk;
  logic                      ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= nb_valid;
    end else if (clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sender <= load_sender;
      tag    <= load_tag;
      vclk   <= load_clock;
    end else if (shift) begin
      sender <= nb_sender;
      tag    <= nb_tag;
      vclk   <= nb_clock;
    end
  end

  always_comb begin
    ok = 1'b1;
    for (int k = 0; k < NUM_PROCS; k++) begin
      if (k == int'(sender)) begin
        if ({1'b0, counts[k*CntW +: CntW]} + 17'd1 != {1'b0, vclk[k*CntW +: CntW]}) ok = 1'b0;
      end else if (counts[k*CntW +: CntW] < vclk[k*CntW +: CntW]) begin
        ok = 1'b0;
      end
    end
    if (int'(sender) >= NUM_PROCS) ok = 1'b0;
  end

  assign stat.valid  = valid;
  assign stat.ready  = valid & ok;
  assign stat.sender = sender;
  assign stat.tag    = tag;
  assign clock_out   = vclk;

endmodule

### rtl/causal_delivery_holdback.sv
// Causal broadcast receive side with a hold-back chain of cells.
// s_axis: one received message per word, tdata = sender, tag, clock_0..4.
// m_axis: result words, tdata = status, from_proc, msg_tag; tlast marks the
// final result of an input.
// One message is in work at a time: s_axis_tready is high only while idle.
// Held or dropped message: its single result is registered from the evaluate
// state once the result register is free, and the block then returns to idle.
// Delivered message: counts update in the evaluate cycle, then each scan
// emits the previous delivery and looks for a ready held entry; a release
// moves from scan to emit and back to scan.
// The result register holds while m_axis_tready is low; scans and the
// evaluation of a held or dropped message wait for it, while the evaluation
// of a delivered message does not.
// Reset clears all delivered counts and empties the hold-back chain.
module causal_delivery_holdback import cdh_pkg::*; #(
  parameter int NUM_PROCS  = NumProcsDefault,
  parameter int HOLD_DEPTH = HoldDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // sender[2:0], tag[18:3], clock_0..clock_4 16 bits each
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,  // status[1:0], from_proc[4:2], msg_tag[20:5]
  output logic         m_axis_tlast
);

  localparam int IdxW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int VW   = NUM_PROCS * CntW;

  state_t state, state_next;

  logic [SendW-1:0] in_sender;
  logic [TagW-1:0]  in_tag;
  logic [VW-1:0]    in_clock;
  logic [VW-1:0]    counts;

  cell_stat_t           stat [HOLD_DEPTH];
  logic [VW-1:0]        cclk [HOLD_DEPTH];
  logic [HOLD_DEPTH-1:0] load_v, shift_v, clear_v;

  logic                 res_valid, res_last, res_load;
  status_t              res_status;
  logic [SendW-1:0]     res_from;
  logic [TagW-1:0]      res_tag;
  logic [SendW-1:0]     pd_from;
  logic [TagW-1:0]      pd_tag;

  logic                 in_ok, full, any_ready, out_free;
  logic [IdxW-1:0]      rel_idx, fill_idx;
  logic [IdxW:0]        nheld;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sender <= s_axis_tdata[2:0];
      in_tag    <= s_axis_tdata[18:3];
      for (int k = 0; k < NUM_PROCS; k++) begin
        in_clock[k*CntW +: CntW] <= (k < ClockFields) ? s_axis_tdata[19 + k*CntW +: CntW]
                                                       : '0;
      end
    end
  end

  always_comb begin
    in_ok = 1'b1;
    for (int k = 0; k < NUM_PROCS; k++) begin
      if (k == int'(in_sender)) begin
        if ({1'b0, counts[k*CntW +: CntW]} + 17'd1 != {1'b0, in_clock[k*CntW +: CntW]}) in_ok = 1'b0;
      end else if (counts[k*CntW +: CntW] < in_clock[k*CntW +: CntW]) begin
        in_ok = 1'b0;
      end
    end
    if (int'(in_sender) >= NUM_PROCS) in_ok = 1'b0;
  end

  always_comb begin
    nheld     = '0;
    any_ready = 1'b0;
    rel_idx   = '0;
    for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
      if (stat[i].ready) begin
        any_ready = 1'b1;
        rel_idx   = IdxW'(i);
      end
    end
    for (int i = 0; i < HOLD_DEPTH; i++) nheld = nheld + (IdxW+1)'(stat[i].valid);
    full     = (nheld == (IdxW+1)'(HOLD_DEPTH));
    fill_idx = nheld[IdxW-1:0];
  end

  assign out_free = !res_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    load_v = '0;
    shift_v = '0;
    clear_v = '0;
    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_EVAL;
      S_EVAL: begin
        if (in_ok) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          state_next = S_IDLE;
          if (!full && int'(in_sender) < NUM_PROCS) load_v[fill_idx] = 1'b1;
        end
      end
      S_SCAN: if (out_free) begin
        if (any_ready) begin
          state_next = S_EMIT;
          for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (IdxW'(i) >= rel_idx) begin
              if (i == HOLD_DEPTH - 1) clear_v[i] = 1'b1;
              else shift_v[i] = 1'b1;
            end
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: state_next = S_SCAN;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (state == S_EVAL && in_ok) begin
      counts[in_sender*CntW +: CntW] <= in_clock[in_sender*CntW +: CntW];
    end else if (state == S_SCAN && out_free && any_ready) begin
      counts[stat[rel_idx].sender*CntW +: CntW] <=
        cclk[rel_idx][stat[rel_idx].sender*CntW +: CntW];
    end
  end

  // hold the latest delivery until the next scan tells whether it is the last
  always_ff @(posedge clk) begin
    if (state == S_EVAL && in_ok) begin
      pd_from <= in_sender;
      pd_tag  <= in_tag;
    end else if (state == S_SCAN && out_free && any_ready) begin
      pd_from <= stat[rel_idx].sender;
      pd_tag  <= stat[rel_idx].tag;
    end
  end

  assign res_load = (((state == S_EVAL) && !in_ok) || (state == S_SCAN)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (state == S_EVAL) begin
        res_status <= (full || int'(in_sender) >= NUM_PROCS) ? ST_DROPPED : ST_HELD;
        res_from   <= in_sender;
        res_tag    <= in_tag;
        res_last   <= 1'b1;
      end else begin
        res_status <= ST_DELIVERED;
        res_from   <= pd_from;
        res_tag    <= pd_tag;
        res_last   <= !any_ready;
      end
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {3'b0, res_tag, res_from, res_status};
  assign m_axis_tlast  = res_last;

  genvar g;
  generate
    for (g = 0; g < HOLD_DEPTH; g++) begin : g_cell
      localparam int N = (g == HOLD_DEPTH - 1) ? g : g + 1;
      cdh_cell #(.NUM_PROCS(NUM_PROCS)) u_cell (
        .clk, .rst,
        .load(load_v[g]), .shift(shift_v[g]), .clear(clear_v[g]),
        .load_sender(in_sender), .load_tag(in_tag), .load_clock(in_clock),
        .nb_valid((g == HOLD_DEPTH - 1) ? 1'b0 : stat[N].valid),
        .nb_sender(stat[N].sender), .nb_tag(stat[N].tag), .nb_clock(cclk[N]),
        .counts(counts), .stat(stat[g]), .clock_out(cclk[g])
      );
    end
  endgenerate

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0(load_v | shift_v | clear_v) || (load_v == '0)) else $error("load with shift");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (load_v != '0) |-> !full) else $error("load into full chain");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");
`endif

endmodule
